[src/lfps_pkg.sv]
package lfps_pkg;

    // apb address and data widths
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd1;
    localparam logic [2:0] REG_WHITE_THR  = 3'd2;
    localparam logic [2:0] REG_BASE_SPEED = 3'd3;
    localparam logic [2:0] REG_LOST_SPEED = 3'd4;
    localparam logic [2:0] REG_RUN_LIMIT  = 3'd5;

    // register reset values
    localparam logic [9:0] PROP_GAIN_RST  = 10'd64;
    localparam logic [9:0] DERIV_GAIN_RST = 10'd32;
    localparam logic [9:0] WHITE_THR_RST  = 10'd200;
    localparam logic [6:0] BASE_SPEED_RST = 7'd40;
    localparam logic [6:0] LOST_SPEED_RST = 7'd25;
    localparam logic [7:0] RUN_LIMIT_RST  = 8'd25;

    // motor action codes
    typedef logic [1:0] t_action;
    localparam t_action ACT_NONE = 2'd0;
    localparam t_action ACT_OFF  = 2'd1;
    localparam t_action ACT_FWD  = 2'd2;
    localparam t_action ACT_REV  = 2'd3;

    // last seen side of the line
    typedef logic [1:0] t_side;
    localparam t_side SIDE_NONE  = 2'd0;
    localparam t_side SIDE_LEFT  = 2'd1;
    localparam t_side SIDE_RIGHT = 2'd2;

    // drive percent ceiling
    localparam logic [6:0] PCT_MAX = 7'd100;

    // input mode codes
    localparam logic MODE_INIT = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

endpackage

[src/lfps_if.sv]
// sample channel
interface lfps_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [9:0] left_sample;
    logic [9:0] right_sample;
    logic [7:0] elapsed_ticks;

    modport source (
        output valid, mode, left_sample, right_sample, elapsed_ticks,
        input  ready
    );
    modport sink (
        input  valid, mode, left_sample, right_sample, elapsed_ticks,
        output ready
    );
endinterface

// motor command channel
interface lfps_out_if;
    logic               valid;
    logic               ready;
    logic               done_res;
    logic [1:0]         left_action;
    logic [6:0]         left_speed;
    logic [1:0]         right_action;
    logic [6:0]         right_speed;
    logic signed [15:0] steer_correction;

    modport source (
        output valid, done_res, left_action, left_speed, right_action, right_speed,
               steer_correction,
        input  ready
    );
    modport sink (
        input  valid, done_res, left_action, left_speed, right_action, right_speed,
               steer_correction,
        output ready
    );
endinterface

[src/line_follow_pd_steer_unit.sv]
// pd steering controller for a two-wheel line follower
//
// i_in carries one beat per control tick: mode 0 clears the stored error and
// side, mode 1 runs one control step on the left/right reflectance samples and
// the elapsed tick count. o_out returns exactly one beat per input beat, in
// order: done flag, per-wheel action and speed, and the saturated correction.
// gains, thresholds, speeds and run limit sit behind the apb port at 4*index;
// the user must write them only while the block is idle; the block does not enforce this.
//
// a beat accepted on i_in passes the input register, product register and
// result register before it is presented on o_out. throughput is one beat
// per cycle while o_out is not stalled; the only loop is the stored error and
// side, which close within the input stage.
// when o_out is stalled the result register holds; the two earlier stages keep
// filling, so up to two more beats are taken before i_in.ready drops.
// a synchronous reset empties the pipeline, clears the stored error and side,
// and loads every config register with its default.
module line_follow_pd_steer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lfps_in_if.sink                       i_in,
    lfps_out_if.source                    o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [lfps_pkg::APB_AW-1:0]   i_paddr,
    input  logic [lfps_pkg::APB_DW-1:0]   i_pwdata,
    output logic [lfps_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready
);

    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_DONE,
        KIND_LOST,
        KIND_FOLLOW
    } t_kind;

    typedef struct packed {
        lfps_pkg::t_action action;
        logic [6:0]        speed;
    } t_wheel;

    // config registers
    logic [9:0] r_prop_gain, r_deriv_gain, r_white_thr;
    logic [6:0] r_base_speed, r_lost_speed;
    logic [7:0] r_run_limit;

    // stored control state
    logic signed [10:0] r_prev_error, n_prev_error;
    lfps_pkg::t_side    r_prev_side, n_prev_side;

    // input stage
    logic       r_a_vld;
    logic       r_a_mode;
    logic [9:0] r_a_left, r_a_right;
    logic [7:0] r_a_ticks;

    // product stage
    logic               r_b_vld;
    t_kind              r_b_kind, n_b_kind;
    lfps_pkg::t_side    r_b_side;
    logic signed [20:0] r_b_pterm;
    logic signed [21:0] r_b_dterm;

    // result register
    logic               r_out_vld;
    logic               r_out_done;
    t_wheel             r_out_left, r_out_right, n_out_left, n_out_right;
    logic signed [15:0] r_out_corr, n_out_corr;

    logic s_en_out, s_en_b, s_en_a;
    logic s_wr;

    logic signed [10:0] s_err;
    logic signed [11:0] s_deriv;
    logic signed [20:0] s_pterm;
    logic signed [21:0] s_dterm;
    logic               s_lost, s_done;

    logic signed [22:0] s_sum;
    logic signed [29:0] s_sum_x, s_scaled, s_biased;
    logic signed [19:0] s_corr;
    logic signed [15:0] s_corr_sat;
    logic signed [20:0] s_left_pct, s_right_pct;
    logic [6:0]         s_lost_spd;

    // wheel command from a signed drive percent
    function automatic t_wheel wheel_cmd(input logic signed [20:0] pct);
        t_wheel w;
        if (pct < 0) begin
            w.action = lfps_pkg::ACT_OFF;
            w.speed  = '0;
        end else begin
            w.action = lfps_pkg::ACT_FWD;
            w.speed  = (pct > 21'sd100) ? lfps_pkg::PCT_MAX : pct[6:0];
        end
        return w;
    endfunction

    // apb port
    assign o_pready = 1'b1;
    assign s_wr     = i_psel & i_penable & i_pwrite;

    always_comb begin
        unique case (i_paddr[4:2])
            lfps_pkg::REG_PROP_GAIN:  o_prdata = 32'(r_prop_gain);
            lfps_pkg::REG_DERIV_GAIN: o_prdata = 32'(r_deriv_gain);
            lfps_pkg::REG_WHITE_THR:  o_prdata = 32'(r_white_thr);
            lfps_pkg::REG_BASE_SPEED: o_prdata = 32'(r_base_speed);
            lfps_pkg::REG_LOST_SPEED: o_prdata = 32'(r_lost_speed);
            lfps_pkg::REG_RUN_LIMIT:  o_prdata = 32'(r_run_limit);
            default:                  o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= lfps_pkg::PROP_GAIN_RST;
            r_deriv_gain <= lfps_pkg::DERIV_GAIN_RST;
            r_white_thr  <= lfps_pkg::WHITE_THR_RST;
            r_base_speed <= lfps_pkg::BASE_SPEED_RST;
            r_lost_speed <= lfps_pkg::LOST_SPEED_RST;
            r_run_limit  <= lfps_pkg::RUN_LIMIT_RST;
        end else if (s_wr) begin
            unique case (i_paddr[4:2])
                lfps_pkg::REG_PROP_GAIN:  r_prop_gain  <= i_pwdata[9:0];
                lfps_pkg::REG_DERIV_GAIN: r_deriv_gain <= i_pwdata[9:0];
                lfps_pkg::REG_WHITE_THR:  r_white_thr  <= i_pwdata[9:0];
                lfps_pkg::REG_BASE_SPEED: r_base_speed <= i_pwdata[6:0];
                lfps_pkg::REG_LOST_SPEED: r_lost_speed <= i_pwdata[6:0];
                lfps_pkg::REG_RUN_LIMIT:  r_run_limit  <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when the next one is empty or moving
    assign s_en_out   = !r_out_vld || o_out.ready;
    assign s_en_b     = !r_b_vld || s_en_out;
    assign s_en_a     = !r_a_vld || s_en_b;
    assign i_in.ready = s_en_a;

    // input stage: error, derivative, classification, products
    assign s_err   = $signed({1'b0, r_a_left}) - $signed({1'b0, r_a_right});
    assign s_deriv = $signed({s_err[10], s_err}) - $signed({r_prev_error[10], r_prev_error});
    assign s_pterm = s_err * $signed({1'b0, r_prop_gain});
    assign s_dterm = s_deriv * $signed({1'b0, r_deriv_gain});
    assign s_lost  = (r_a_left < r_white_thr) && (r_a_right < r_white_thr);
    assign s_done  = r_a_ticks > r_run_limit;

    always_comb begin
        n_prev_error = r_prev_error;
        n_prev_side  = r_prev_side;
        if (r_a_mode == lfps_pkg::MODE_INIT) begin
            n_b_kind     = KIND_INIT;
            n_prev_error = '0;
            n_prev_side  = lfps_pkg::SIDE_NONE;
        end else if (s_done) begin
            n_b_kind = KIND_DONE;
        end else if (s_lost) begin
            n_b_kind     = KIND_LOST;
            n_prev_error = s_err;
        end else begin
            n_b_kind     = KIND_FOLLOW;
            n_prev_error = s_err;
            n_prev_side  = s_err[10] ? lfps_pkg::SIDE_LEFT : lfps_pkg::SIDE_RIGHT;
        end
    end

    // result stage: scale by 100/1024 toward zero, wheel mixing
    assign s_sum    = 23'(r_b_pterm) + 23'(r_b_dterm);
    assign s_sum_x  = 30'(s_sum);
    assign s_scaled = (s_sum_x <<< 6) + (s_sum_x <<< 5) + (s_sum_x <<< 2);
    assign s_biased = s_scaled + (s_scaled[29] ? 30'sd1023 : 30'sd0);
    assign s_corr   = s_biased[29:10];

    assign s_corr_sat  = (s_corr > 20'sd32767)  ? 16'sh7fff :
                         (s_corr < -20'sd32768) ? 16'sh8000 : s_corr[15:0];
    assign s_left_pct  = $signed({14'b0, r_base_speed}) - 21'(s_corr);
    assign s_right_pct = $signed({14'b0, r_base_speed}) + 21'(s_corr);
    assign s_lost_spd  = (r_lost_speed > lfps_pkg::PCT_MAX) ? lfps_pkg::PCT_MAX : r_lost_speed;

    always_comb begin
        n_out_left  = '{action: lfps_pkg::ACT_NONE, speed: '0};
        n_out_right = '{action: lfps_pkg::ACT_NONE, speed: '0};
        n_out_corr  = '0;
        unique case (r_b_kind)
            KIND_LOST: begin
                if (r_b_side == lfps_pkg::SIDE_LEFT) begin
                    n_out_left  = '{action: lfps_pkg::ACT_REV, speed: s_lost_spd};
                    n_out_right = '{action: lfps_pkg::ACT_FWD, speed: s_lost_spd};
                end else if (r_b_side == lfps_pkg::SIDE_RIGHT) begin
                    n_out_left  = '{action: lfps_pkg::ACT_FWD, speed: s_lost_spd};
                    n_out_right = '{action: lfps_pkg::ACT_REV, speed: s_lost_spd};
                end
            end
            KIND_FOLLOW: begin
                n_out_left  = wheel_cmd(s_left_pct);
                n_out_right = wheel_cmd(s_right_pct);
                n_out_corr  = s_corr_sat;
            end
            default: ;
        endcase
    end

    // pipeline and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
            r_prev_error <= '0;
            r_prev_side  <= lfps_pkg::SIDE_NONE;
        end else begin
            if (s_en_a) begin
                r_a_vld   <= i_in.valid;
                r_a_mode  <= i_in.mode;
                r_a_left  <= i_in.left_sample;
                r_a_right <= i_in.right_sample;
                r_a_ticks <= i_in.elapsed_ticks;
            end
            if (s_en_b) begin
                r_b_vld   <= r_a_vld;
                r_b_kind  <= n_b_kind;
                r_b_side  <= r_prev_side;
                r_b_pterm <= s_pterm;
                r_b_dterm <= s_dterm;
                if (r_a_vld) begin
                    r_prev_error <= n_prev_error;
                    r_prev_side  <= n_prev_side;
                end
            end
            if (s_en_out) begin
                r_out_vld   <= r_b_vld;
                r_out_done  <= (r_b_kind == KIND_DONE);
                r_out_left  <= n_out_left;
                r_out_right <= n_out_right;
                r_out_corr  <= n_out_corr;
            end
        end
    end

    // result beat
    assign o_out.valid            = r_out_vld;
    assign o_out.done_res         = r_out_done;
    assign o_out.left_action      = r_out_left.action;
    assign o_out.left_speed       = r_out_left.speed;
    assign o_out.right_action     = r_out_right.action;
    assign o_out.right_speed      = r_out_right.speed;
    assign o_out.steer_correction = r_out_corr;

`ifndef SYNTHESIS
    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled with empty result register");

    // stored side never holds the unused code
    a_side_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_side != 2'd3)
        else $error("stored side corrupted");

    // a done beat carries no motor command
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_done |->
            r_out_left.action == lfps_pkg::ACT_NONE &&
            r_out_right.action == lfps_pkg::ACT_NONE && r_out_corr == 16'sd0)
        else $error("done beat with motor command");

    // speeds never exceed full drive and an off left motor reports zero
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out_left.speed <= lfps_pkg::PCT_MAX &&
            r_out_right.speed <= lfps_pkg::PCT_MAX &&
            (r_out_left.action != lfps_pkg::ACT_OFF || r_out_left.speed == 7'd0))
        else $error("wheel speed out of range");

    // a mode 0 beat leaving the input stage clears the stored state
    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && s_en_b && r_a_mode == lfps_pkg::MODE_INIT |=>
            r_prev_error == 11'sd0 && r_prev_side == lfps_pkg::SIDE_NONE)
        else $error("initialize did not clear state");
`endif

endmodule

[tb/sv/line_follow_pd_steer_unit_tb.sv]
module line_follow_pd_steer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    localparam int N_PHASES    = 10;
    localparam int PHASE_BEATS = 103;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 19;

    // one sample beat
    typedef struct packed {
        logic       mode;
        logic [9:0] left;
        logic [9:0] right;
        logic [7:0] ticks;
    } sample_t;

    // one motor command beat
    typedef struct packed {
        logic               done;
        t_action            l_act;
        logic [6:0]         l_spd;
        t_action            r_act;
        logic [6:0]         r_spd;
        logic signed [15:0] corr;
    } motor_cmd_t;

    typedef struct packed {
        logic [9:0] prop_gain;
        logic [9:0] deriv_gain;
        logic [9:0] white_thr;
        logic [6:0] base_speed;
        logic [6:0] lost_speed;
        logic [7:0] run_limit;
    } steer_cfg_t;

    typedef struct packed {
        sample_t    s;
        logic       fixed;
        motor_cmd_t want;
    } dir_row_t;

    // commands that can be read straight off the spec at reset settings
    localparam motor_cmd_t IDLE_CMD   = '0;
    localparam motor_cmd_t DONE_CMD   = {1'b1, ACT_NONE, 7'd0, ACT_NONE, 7'd0, 16'sd0};
    localparam motor_cmd_t SPIN_RIGHT =
        {1'b0, ACT_FWD, LOST_SPEED_RST, ACT_REV, LOST_SPEED_RST, 16'sd0};
    localparam motor_cmd_t SPIN_LEFT  =
        {1'b0, ACT_REV, LOST_SPEED_RST, ACT_FWD, LOST_SPEED_RST, 16'sd0};
    localparam motor_cmd_t CRUISE_CMD =
        {1'b0, ACT_FWD, BASE_SPEED_RST, ACT_FWD, BASE_SPEED_RST, 16'sd0};

    localparam logic [2:0] REG_LIST [6] = '{REG_PROP_GAIN, REG_DERIV_GAIN, REG_WHITE_THR,
                                            REG_BASE_SPEED, REG_LOST_SPEED, REG_RUN_LIMIT};

    logic i_clk;
    logic i_rst_n;
    logic i_psel;
    logic i_penable;
    logic i_pwrite;
    logic [APB_AW-1:0] i_paddr;
    logic [APB_DW-1:0] i_pwdata;
    logic [APB_DW-1:0] o_prdata;
    logic o_pready;

    lfps_in_if  smp_if ();
    lfps_out_if cmd_if ();

    line_follow_pd_steer_unit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (smp_if),
        .o_out     (cmd_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // predictor state and register copy
    steer_cfg_t        steer_cfg;
    logic signed [10:0] held_err;
    t_side             held_side;

    motor_cmd_t pending_cmds [$];
    int         fault_cnt;
    int         cycle_cnt;
    bit         idle_on;
    dir_row_t   dir_tab [N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run watchdog
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic void report_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10) $display("%s", msg);
    endfunction

    function automatic void wheel_drive(input longint pct, output t_action act,
                                        output logic [6:0] spd);
        if (pct < 0) begin
            act = ACT_OFF;
            spd = '0;
        end else begin
            act = ACT_FWD;
            spd = (pct > 100) ? PCT_MAX : pct[6:0];
        end
    endfunction

    // pd steering step, updates the held error and side
    function automatic motor_cmd_t steer_predict(input sample_t s);
        motor_cmd_t c;
        int         err, slope, kp, kd, base;
        longint     corr;
        logic [6:0] spin;
        c = '0;
        if (s.mode == MODE_INIT) begin
            held_err  = '0;
            held_side = SIDE_NONE;
            return c;
        end
        if (s.ticks > steer_cfg.run_limit) begin
            c.done = 1'b1;
            return c;
        end
        err   = int'(s.left) - int'(s.right);
        slope = err - int'(held_err);
        if (s.left < steer_cfg.white_thr && s.right < steer_cfg.white_thr) begin
            // line lost: spin toward the last seen side
            spin = (steer_cfg.lost_speed > PCT_MAX) ? PCT_MAX : steer_cfg.lost_speed;
            if (held_side == SIDE_LEFT) begin
                c.l_act = ACT_REV;
                c.l_spd = spin;
                c.r_act = ACT_FWD;
                c.r_spd = spin;
            end else if (held_side == SIDE_RIGHT) begin
                c.l_act = ACT_FWD;
                c.l_spd = spin;
                c.r_act = ACT_REV;
                c.r_spd = spin;
            end
        end else begin
            kp   = steer_cfg.prop_gain;
            kd   = steer_cfg.deriv_gain;
            base = steer_cfg.base_speed;
            corr = (longint'(err) * kp + longint'(slope) * kd) * 100 / 1024;
            wheel_drive(longint'(base) - corr, c.l_act, c.l_spd);
            wheel_drive(longint'(base) + corr, c.r_act, c.r_spd);
            if (corr > 32767) c.corr = 16'sh7fff;
            else if (corr < -32768) c.corr = 16'sh8000;
            else c.corr = corr[15:0];
            held_side = (err < 0) ? SIDE_LEFT : SIDE_RIGHT;
        end
        held_err = err[10:0];
        return c;
    endfunction

    task automatic apb_access(input logic wr, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= wdata;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // write every register with junk above its width, then read it back
    task automatic load_config(input steer_cfg_t c);
        logic [31:0] val, mask, rd;
        foreach (REG_LIST[k]) begin
            case (REG_LIST[k])
                REG_PROP_GAIN:  begin val = 32'(c.prop_gain);  mask = 32'h3ff; end
                REG_DERIV_GAIN: begin val = 32'(c.deriv_gain); mask = 32'h3ff; end
                REG_WHITE_THR:  begin val = 32'(c.white_thr);  mask = 32'h3ff; end
                REG_BASE_SPEED: begin val = 32'(c.base_speed); mask = 32'h7f;  end
                REG_LOST_SPEED: begin val = 32'(c.lost_speed); mask = 32'h7f;  end
                default:        begin val = 32'(c.run_limit);  mask = 32'hff;  end
            endcase
            apb_access(1'b1, REG_LIST[k], val | ($urandom & ~mask), rd);
            apb_access(1'b0, REG_LIST[k], '0, rd);
            if (rd !== val)
                report_fault($sformatf("reg %0d readback: want %0h got %0h",
                                       REG_LIST[k], val, rd));
        end
        steer_cfg = c;
    endtask

    // one sample beat, with an optional random gap ahead of it
    task automatic send_sample(input sample_t s, input logic fixed, input motor_cmd_t want);
        motor_cmd_t pred;
        int         gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            smp_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid         <= 1'b1;
        smp_if.mode          <= s.mode;
        smp_if.left_sample   <= s.left;
        smp_if.right_sample  <= s.right;
        smp_if.elapsed_ticks <= s.ticks;
        do @(posedge i_clk); while (!smp_if.ready);
        pred = steer_predict(s);
        pending_cmds.push_back(fixed ? want : pred);
    endtask

    task automatic drain_cmds();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // command sink with random stall bursts
    initial begin
        int stall_left;
        stall_left   = 0;
        cmd_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                cmd_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left   = $urandom_range(0, 3);
                cmd_if.ready <= 1'b0;
            end else begin
                cmd_if.ready <= 1'b1;
            end
        end
    end

    // command checker
    always @(posedge i_clk) begin : cmd_check
        motor_cmd_t got, want;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            got = {cmd_if.done_res, cmd_if.left_action, cmd_if.left_speed,
                   cmd_if.right_action, cmd_if.right_speed, cmd_if.steer_correction};
            if (pending_cmds.size() == 0) begin
                report_fault("command beat with nothing pending");
            end else begin
                want = pending_cmds.pop_front();
                if (got !== want)
                    report_fault($sformatf(
                        {"cmd mismatch: want done=%0d la=%0d ls=%0d ra=%0d rs=%0d corr=%0d",
                         " | got done=%0d la=%0d ls=%0d ra=%0d rs=%0d corr=%0d"},
                        want.done, want.l_act, want.l_spd, want.r_act, want.r_spd,
                        want.corr, got.done, got.l_act, got.l_spd, got.r_act, got.r_spd,
                        got.corr));
            end
        end
    end

    // stimulus
    initial begin
        sample_t    s;
        steer_cfg_t nxt;
        int         pick;

        fault_cnt            = 0;
        idle_on              = 1'b1;
        i_rst_n              = 1'b0;
        i_psel               = 1'b0;
        i_penable            = 1'b0;
        i_pwrite             = 1'b0;
        i_paddr              = '0;
        i_pwdata             = '0;
        smp_if.valid         = 1'b0;
        smp_if.mode          = MODE_INIT;
        smp_if.left_sample   = '0;
        smp_if.right_sample  = '0;
        smp_if.elapsed_ticks = '0;

        steer_cfg = {PROP_GAIN_RST, DERIV_GAIN_RST, WHITE_THR_RST,
                     BASE_SPEED_RST, LOST_SPEED_RST, RUN_LIMIT_RST};
        held_err  = '0;
        held_side = SIDE_NONE;

        dir_tab = '{
            {MODE_INIT, 10'd0,    10'd0,    8'd0,   1'b1, IDLE_CMD},
            {MODE_RUN,  10'd0,    10'd0,    8'd0,   1'b1, IDLE_CMD},   // lost, no side yet
            {MODE_RUN,  10'd1023, 10'd0,    8'd0,   1'b0, IDLE_CMD},
            {MODE_RUN,  10'd0,    10'd0,    8'd0,   1'b1, SPIN_RIGHT},
            {MODE_RUN,  10'd0,    10'd1023, 8'd25,  1'b0, IDLE_CMD},   // ticks at the limit
            {MODE_RUN,  10'd100,  10'd100,  8'd0,   1'b1, SPIN_LEFT},
            {MODE_RUN,  10'd1023, 10'd1023, 8'd255, 1'b1, DONE_CMD},
            {MODE_RUN,  10'd512,  10'd512,  8'd26,  1'b1, DONE_CMD},
            {MODE_RUN,  10'd512,  10'd512,  8'd0,   1'b1, CRUISE_CMD},
            {MODE_INIT, 10'd1023, 10'd1023, 8'd255, 1'b1, IDLE_CMD},
            {MODE_RUN,  10'd0,    10'd0,    8'd0,   1'b1, IDLE_CMD},   // side cleared by init
            {MODE_RUN,  10'd200,  10'd199,  8'd0,   1'b0, IDLE_CMD},   // one side at threshold
            {MODE_RUN,  10'd199,  10'd199,  8'd0,   1'b1, SPIN_RIGHT},
            {MODE_RUN,  10'd0,    10'd200,  8'd0,   1'b0, IDLE_CMD},
            {MODE_RUN,  10'd1023, 10'd1023, 8'd0,   1'b0, IDLE_CMD},
            {MODE_RUN,  10'd700,  10'd300,  8'd128, 1'b1, DONE_CMD},
            {MODE_RUN,  10'd300,  10'd700,  8'd0,   1'b0, IDLE_CMD},
            {MODE_RUN,  10'd1022, 10'd1,    8'd1,   1'b0, IDLE_CMD},   // wheel off and clipped
            {MODE_RUN,  10'd1,    10'd1022, 8'd24,  1'b0, IDLE_CMD}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        foreach (dir_tab[r])
            send_sample(dir_tab[r].s, dir_tab[r].fixed, dir_tab[r].want);

        // random phases, each under its own register setting
        for (int ph = 1; ph <= N_PHASES; ph++) begin
            drain_cmds();
            case (ph)
                1: nxt = '0;
                2: nxt = '1;
                3: nxt = {10'd1023, 10'd0, 10'd512, PCT_MAX, PCT_MAX, 8'd255};
                default: begin
                    nxt.prop_gain  = 10'($urandom);
                    nxt.deriv_gain = 10'($urandom);
                    nxt.white_thr  = 10'($urandom);
                    nxt.base_speed = ($urandom_range(0, 5) == 0) ? 7'($urandom)
                                                                 : 7'($urandom_range(0, 100));
                    nxt.lost_speed = ($urandom_range(0, 5) == 0) ? 7'($urandom)
                                                                 : 7'($urandom_range(0, 100));
                    nxt.run_limit  = 8'($urandom);
                end
            endcase
            load_config(nxt);
            idle_on = (ph < N_PHASES - 1) ? ($urandom_range(0, 4) != 0) : 1'b0;

            repeat (PHASE_BEATS) begin
                s.mode  = ($urandom_range(0, 15) == 0) ? MODE_INIT : MODE_RUN;
                s.ticks = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, steer_cfg.run_limit));
                pick = $urandom_range(0, 7);
                if (pick == 0 && steer_cfg.white_thr != 0) begin
                    // both sides below threshold
                    s.left  = 10'($urandom_range(0, steer_cfg.white_thr - 1));
                    s.right = 10'($urandom_range(0, steer_cfg.white_thr - 1));
                end else if (pick == 1) begin
                    s.left  = 10'($urandom);
                    s.right = s.left;
                end else if (pick == 2) begin
                    s.left  = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                    s.right = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                end else begin
                    s.left  = 10'($urandom);
                    s.right = 10'($urandom);
                end
                send_sample(s, 1'b0, IDLE_CMD);
            end
        end

        drain_cmds();
        repeat (8) @(posedge i_clk);
        if (fault_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
src/lfps_pkg.sv
src/lfps_if.sv
src/line_follow_pd_steer_unit.sv
tb/sv/line_follow_pd_steer_unit_tb.sv
